FILE: src/dense_set_swap_remove_pick_defines.svh
// Assertion macros shared by the checker files of the dense set block.
// No dependencies; the macros expect signals named clock and reset in scope.
`ifndef DENSE_SET_SWAP_REMOVE_PICK_DEFINES_SVH
`define DENSE_SET_SWAP_REMOVE_PICK_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DSRP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DSRP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/dsrp_pkg.sv
// Package for the dense set block: item types, action and status codes.
// No dependencies; used by every module of the block.
package dsrp_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_PICK   = 2'd2;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_PRESENCE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] value;
      logic [15:0]        random_word;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] picked_value;
      logic [4:0]         member_count;
   } rsp_type;

endpackage

FILE: src/dsrp_table.sv
// Member table and count of the dense set, with the lookup and update logic.
// Depends on dsrp_pkg for the item types and codes.
module dsrp_table #(
   parameter int TABLE_DEPTH = dsrp_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  dsrp_pkg::req_type req_data,
   output dsrp_pkg::rsp_type result
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [31:0]          entry_ff [TABLE_DEPTH];
   logic [31:0]          entry_in [TABLE_DEPTH];
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [CNT_W-1:0]     count_after;
   logic [CNT_W-1:0]     last_cnt;
   logic [TABLE_DEPTH-1:0] match;
   logic                 found;
   logic                 full;
   logic                 empty;
   logic                 ins_ok;
   logic                 rem_ok;
   logic [IDX_W-1:0]     hit_idx;
   logic [IDX_W-1:0]     last_idx;
   logic [IDX_W-1:0]     pick_idx;
   logic [CNT_W+15:0]    pick_prod;
   logic [1:0]           status;
   logic [31:0]          picked;
   logic [CNT_W+4:0]     count_ext;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (entry_ff[i] == $unsigned(req_data.value));
      end
   end

   // Members are distinct, so at most one match bit is set.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (match[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   assign found     = |match;
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign empty     = (count_ff == '0);
   assign last_cnt  = count_ff - CNT_W'(1);
   assign last_idx  = last_cnt[IDX_W-1:0];
   assign pick_prod = (CNT_W + 16)'(req_data.random_word) * (CNT_W + 16)'(count_ff);
   assign pick_idx  = pick_prod[16 +: IDX_W];

   always_comb begin
      status = dsrp_pkg::ST_DONE;
      picked = '0;
      ins_ok = 1'b0;
      rem_ok = 1'b0;
      case (req_data.action)
         dsrp_pkg::ACT_INSERT: begin
            if (found) begin
               status = dsrp_pkg::ST_PRESENCE;
            end else if (full) begin
               status = dsrp_pkg::ST_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         dsrp_pkg::ACT_REMOVE: begin
            if (found) begin
               rem_ok = 1'b1;
            end else begin
               status = dsrp_pkg::ST_PRESENCE;
            end
         end
         dsrp_pkg::ACT_PICK: begin
            if (empty) begin
               status = dsrp_pkg::ST_EMPTY;
            end else begin
               picked = entry_ff[pick_idx];
            end
         end
         default: begin
            status = dsrp_pkg::ST_DONE;
         end
      endcase
   end

   always_comb begin
      if (ins_ok) begin
         count_after = count_ff + CNT_W'(1);
      end else if (rem_ok) begin
         count_after = last_cnt;
      end else begin
         count_after = count_ff;
      end
      count_in = req_fire ? count_after : count_ff;
   end

   // The last member moves into the hole left by a removed value.
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
         if (req_fire && ins_ok && (count_ff == CNT_W'(i))) begin
            entry_in[i] = $unsigned(req_data.value);
         end
         if (req_fire && rem_ok && (hit_idx == IDX_W'(i))) begin
            entry_in[i] = entry_ff[last_idx];
         end
      end
   end

   assign count_ext           = {5'b0, count_after};
   assign result.status       = status;
   assign result.picked_value = $signed(picked);
   assign result.member_count = count_ext[4:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: src/dsrp_skid.sv
// Result register with a skid stage, so the request side never waits on a
// single stalled result. Depends on dsrp_pkg for the result type.
module dsrp_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dsrp_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output dsrp_pkg::rsp_type out_data
);

   logic              out_valid_ff;
   logic              out_valid_in;
   dsrp_pkg::rsp_type out_data_ff;
   dsrp_pkg::rsp_type out_data_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   dsrp_pkg::rsp_type skid_data_ff;
   dsrp_pkg::rsp_type skid_data_in;
   logic              in_fire;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_fire;
            if (in_fire) begin
               out_data_in = in_data;
            end
         end
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

FILE: src/dense_set_swap_remove_pick.sv
// Dense set with swap-remove and random pick: top level.
// An accepted item's result is registered, in the skid stage if the output stalls.
// Throughput is one item per cycle while the skid stage is empty, set by the
// combinational compare and update. Reset clears the member count and both result
// stages; table entries are not cleared and are read only after being written.
module dense_set_swap_remove_pick #(
   parameter int TABLE_DEPTH = dsrp_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dsrp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dsrp_pkg::rsp_type rsp_data
);

   logic              req_fire;
   dsrp_pkg::rsp_type result;

   assign req_fire = req_valid && req_ready;

   dsrp_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .result   (result)
   );

   dsrp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

FILE: src/dsrp_checker.sv
// Port-level checker for the dense set block, attached to the top level by bind.
// Depends on dsrp_pkg and on the assertion macros of the defines header.
`include "dense_set_swap_remove_pick_defines.svh"

module dsrp_checker #(
   parameter int TABLE_DEPTH = dsrp_pkg::DEFAULT_TABLE_DEPTH
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dsrp_pkg::rsp_type rsp_data
);

   localparam int FULL_MOD = TABLE_DEPTH % 32;

   logic rsp_stall;
   logic pick_seen;
   logic status_done;
   logic empty_seen;
   logic no_members;
   logic full_seen;
   logic count_at_depth;

   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign pick_seen      = rsp_valid && (rsp_data.picked_value != '0);
   assign status_done    = (rsp_data.status == dsrp_pkg::ST_DONE);
   assign empty_seen     = rsp_valid && (rsp_data.status == dsrp_pkg::ST_EMPTY);
   assign no_members     = (rsp_data.member_count == '0);
   assign full_seen      = rsp_valid && (rsp_data.status == dsrp_pkg::ST_FULL);
   assign count_at_depth = (rsp_data.member_count == 5'(FULL_MOD));

   `DSRP_ASSERT_NEXT(a_rsp_valid_holds, rsp_stall, rsp_valid, "Stalled result item dropped.")
   `DSRP_ASSERT_NEXT(a_rsp_data_holds, rsp_stall, $stable(rsp_data), "Stalled result changed.")
   `DSRP_ASSERT_NOW(a_pick_only_done, pick_seen, status_done, "Picked value on a failed item.")
   `DSRP_ASSERT_NOW(a_empty_count, empty_seen, no_members, "Empty status with members left.")
   `DSRP_ASSERT_NOW(a_full_count, full_seen, count_at_depth, "Full status with room left.")

endmodule

bind dense_set_swap_remove_pick dsrp_checker #(
   .TABLE_DEPTH(TABLE_DEPTH)
) u_dsrp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
